// File: rtl/core/ebrx_pkg.sv
`default_nettype none

package ebrx_pkg;

	// operation codes, codes twelve to fifteen only advance the pc
	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_MOVI = 4'd3,
		OP_BEQZ = 4'd4,
		OP_ANDI = 4'd5,
		OP_EOR  = 4'd6,
		OP_BR   = 4'd7,
		OP_SAL  = 4'd8,
		OP_SAR  = 4'd9,
		OP_LDR  = 4'd10,
		OP_STR  = 4'd11
	} op_t;

	localparam int unsigned DATA_W  = 8;
	localparam int unsigned FLAGS_W = 5;
	localparam int unsigned IDX_W   = 6;

	// status flag bit positions
	localparam int unsigned FLAG_Z = 0;
	localparam int unsigned FLAG_S = 1;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_V = 3;
	localparam int unsigned FLAG_C = 4;

	// execute unit result toward writeback
	typedef struct packed {
		logic [DATA_W-1:0]  result;
		logic               wr_reg;
		logic               set_flags;
		logic [FLAGS_W-1:0] flags;
	} alu_out_t;

endpackage

`default_nettype wire

// File: rtl/core/ebrx_alu.sv
`default_nettype none

module ebrx_alu
	import ebrx_pkg::*;
(
	input  var op_t                op,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	input  wire logic [DATA_W-1:0] imm8,
	input  wire logic [DATA_W-1:0] mdata,
	output alu_out_t               res
);

	logic [DATA_W:0]     w9;
	logic [2*DATA_W-1:0] prod;
	logic [3*DATA_W-1:0] sh;
	logic [DATA_W-1:0]   r;
	logic                v;
	logic                c;

	// operation select and flag generation
	always_comb begin
		w9   = '0;
		prod = '0;
		sh   = '0;
		r    = '0;
		v    = 1'b0;
		c    = 1'b0;
		res  = '0;
		unique case (op)
			OP_ADD: begin
				w9 = {1'b0, a} + {1'b0, b};
				r  = w9[DATA_W-1:0];
				v  = ~(a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1]);
				c  = w9[DATA_W];
				res.wr_reg    = 1'b1;
				res.set_flags = 1'b1;
			end
			OP_SUB: begin
				w9 = {1'b0, a} - {1'b0, b};
				r  = w9[DATA_W-1:0];
				v  = (a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1]);
				c  = w9[DATA_W];
				res.wr_reg    = 1'b1;
				res.set_flags = 1'b1;
			end
			OP_MUL: begin
				prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
				r    = prod[DATA_W-1:0];
				c    = prod[DATA_W];
				res.wr_reg    = 1'b1;
				res.set_flags = 1'b1;
			end
			OP_MOVI: begin
				r = imm8;
				res.wr_reg = 1'b1;
			end
			OP_ANDI: begin
				r = a & imm8;
				res.wr_reg    = 1'b1;
				res.set_flags = 1'b1;
			end
			OP_EOR: begin
				r = a ^ b;
				res.wr_reg    = 1'b1;
				res.set_flags = 1'b1;
			end
			OP_SAL: begin
				// amounts of sixteen and up clear everything including carry
				sh = {{(2*DATA_W){1'b0}}, a} << imm8[3:0];
				if (imm8[7:4] == 4'd0) begin
					r = sh[DATA_W-1:0];
					c = sh[DATA_W];
				end
				res.wr_reg    = 1'b1;
				res.set_flags = 1'b1;
			end
			OP_SAR: begin
				// amounts of eight and up fill with the sign
				if (imm8[7:3] != 5'd0) begin
					r = {DATA_W{a[DATA_W-1]}};
				end else begin
					r = DATA_W'($signed(a) >>> imm8[2:0]);
				end
				res.wr_reg    = 1'b1;
				res.set_flags = 1'b1;
			end
			OP_LDR: begin
				r = mdata;
				res.wr_reg = 1'b1;
			end
			default: begin
			end
		endcase
		res.result        = r;
		res.flags[FLAG_Z] = (r == '0);
		res.flags[FLAG_N] = r[DATA_W-1];
		res.flags[FLAG_V] = v;
		res.flags[FLAG_C] = c;
		res.flags[FLAG_S] = r[DATA_W-1] ^ v;
	end

endmodule

`default_nettype wire

// File: rtl/core/eight_bit_risc_execute.sv
`default_nettype none

// Execute stage of a small 8-bit processor with 64 registers and a 64-byte
// data store. Each input item is one decoded instruction (op_code, dest_reg,
// operand, imm_negative); each yields exactly one output item with the new
// pc, the status flags, the destination register value and a branch mark.
// Input items are taken on in_valid with in_stall low, output items leave on
// out_valid with out_stall low.
// The accept edge issues the register file and data store reads; the
// execute stage then executes, writes back and loads the output register,
// from which the item leaves on out_valid. Throughput is one item per
// cycle while out_stall stays low, set by the single write port of each
// memory; a result written at the same edge as the next item's read is
// forwarded to that item.
// Reset clears pc, flags and the valid bits of both memories, so every
// register and data byte reads as zero until written; no clearing pass.
// While out_stall holds a waiting output item, the execute stage holds its
// item and in_stall rises once that stage is also full; nothing is dropped.
module eight_bit_risc_execute
	import ebrx_pkg::*;
#(
	parameter int unsigned PROGRAM_WORDS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [3:0]        op_code,
	input  wire logic [IDX_W-1:0]  dest_reg,
	input  wire logic [IDX_W-1:0]  operand,
	input  wire logic              imm_negative,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [9:0]             next_pc,
	output logic [FLAGS_W-1:0]     status_flags,
	output logic signed [DATA_W-1:0] reg_value,
	output logic                   branch_taken
);

	localparam int unsigned PW        = $clog2(PROGRAM_WORDS);
	localparam int unsigned MW        = PW + 9;
	localparam int unsigned MOD_STEPS = 4;
	localparam int unsigned ENTRIES   = 64;

	// byte reduced modulo the program size, restoring steps
	function automatic logic [PW-1:0] mod_prog(input logic [7:0] x);
		logic [MW-1:0] rem;
		logic [MW-1:0] sub;
		rem = MW'(x);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			sub = MW'(PROGRAM_WORDS) << k;
			if (rem >= sub) begin
				rem = rem - sub;
			end
		end
		return rem[PW-1:0];
	endfunction

	// handshake and stage control
	logic valid_s1_q;
	logic out_valid_q;
	logic s1_adv;
	logic s1_fire;
	logic in_acc;

	// stage 1 item
	logic [3:0]       op_s1;
	logic [IDX_W-1:0] rd_s1;
	logic [IDX_W-1:0] opd_s1;
	logic             neg_s1;

	// memories and their valid bits
	logic [DATA_W-1:0]  rf_mem [ENTRIES];
	logic [DATA_W-1:0]  ds_mem [ENTRIES];
	logic [ENTRIES-1:0] rf_vld_q;
	logic [ENTRIES-1:0] ds_vld_q;

	// read data and forwarding
	logic [DATA_W-1:0] rf_a_s1;
	logic [DATA_W-1:0] rf_b_s1;
	logic [DATA_W-1:0] ds_s1;
	logic              rfv_a_s1;
	logic              rfv_b_s1;
	logic              dsv_s1;
	logic              fwd_a_s1;
	logic              fwd_b_s1;
	logic              fwd_m_s1;
	logic [DATA_W-1:0] fwd_rdata_s1;
	logic [DATA_W-1:0] fwd_mdata_s1;

	// architectural state
	logic [PW-1:0]      pc_q;
	logic [FLAGS_W-1:0] flags_q;

	// execute signals
	op_t               op_e;
	logic [DATA_W-1:0] a_val;
	logic [DATA_W-1:0] b_val;
	logic [DATA_W-1:0] m_val;
	logic [DATA_W-1:0] imm8;
	alu_out_t          res;
	logic              is_str;
	logic [PW-1:0]     pc_inc;
	logic [PW-1:0]     pc_new;
	logic [PW-1:0]     off;
	logic [PW:0]       sum;
	logic [PW:0]       diff;
	logic              taken;
	logic [PW+9:0]     pc_ext;

	// output register
	logic [9:0]         next_pc_q;
	logic [FLAGS_W-1:0] flags_out_q;
	logic [DATA_W-1:0]  reg_value_q;
	logic               taken_q;

	// handshake
	assign s1_adv   = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1_q && s1_adv;
	assign in_stall = valid_s1_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1_q <= 1'b1;
			end else if (s1_adv) begin
				valid_s1_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1_q;
			end
		end
	end

	// stage 1 item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= op_code;
			rd_s1  <= dest_reg;
			opd_s1 <= operand;
			neg_s1 <= imm_negative;
		end
	end

	// operand values with forwarding and unwritten entries as zero
	assign a_val = fwd_a_s1 ? fwd_rdata_s1 : (rfv_a_s1 ? rf_a_s1 : '0);
	assign b_val = fwd_b_s1 ? fwd_rdata_s1 : (rfv_b_s1 ? rf_b_s1 : '0);
	assign m_val = fwd_m_s1 ? fwd_mdata_s1 : (dsv_s1 ? ds_s1 : '0);
	assign op_e  = op_t'(op_s1);
	assign imm8  = neg_s1 ? (8'd0 - {2'b00, opd_s1}) : {2'b00, opd_s1};
	assign is_str = (op_e == OP_STR);

	ebrx_alu u_alu (
		.op    (op_e),
		.a     (a_val),
		.b     (b_val),
		.imm8  (imm8),
		.mdata (m_val),
		.res   (res)
	);

	// register file: two reads, one write; data store: one read, one write
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rf_a_s1 <= rf_mem[dest_reg];
			rf_b_s1 <= rf_mem[operand];
			ds_s1   <= ds_mem[operand];
		end
		if (s1_fire && res.wr_reg) begin
			rf_mem[rd_s1] <= res.result;
		end
		if (s1_fire && is_str) begin
			ds_mem[opd_s1] <= a_val;
		end
	end

	// valid bits and forwarding marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			ds_vld_q <= '0;
			rfv_a_s1 <= 1'b0;
			rfv_b_s1 <= 1'b0;
			dsv_s1   <= 1'b0;
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
			fwd_m_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				rfv_a_s1 <= rf_vld_q[dest_reg];
				rfv_b_s1 <= rf_vld_q[operand];
				dsv_s1   <= ds_vld_q[operand];
				fwd_a_s1 <= s1_fire && res.wr_reg && (rd_s1 == dest_reg);
				fwd_b_s1 <= s1_fire && res.wr_reg && (rd_s1 == operand);
				fwd_m_s1 <= s1_fire && is_str && (opd_s1 == operand);
			end
			if (s1_fire && res.wr_reg) begin
				rf_vld_q[rd_s1] <= 1'b1;
			end
			if (s1_fire && is_str) begin
				ds_vld_q[opd_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fwd_rdata_s1 <= res.result;
			fwd_mdata_s1 <= a_val;
		end
	end

	// next pc
	always_comb begin
		pc_inc = (pc_q == PW'(PROGRAM_WORDS - 1)) ? '0 : pc_q + 1'b1;
		off    = mod_prog({2'b00, opd_s1});
		sum    = {1'b0, pc_inc} + {1'b0, off};
		diff   = {1'b0, pc_inc} - {1'b0, off};
		pc_new = pc_inc;
		taken  = 1'b0;
		unique case (op_e)
			OP_BEQZ: begin
				if (a_val == '0) begin
					taken = 1'b1;
					if (neg_s1) begin
						pc_new = diff[PW] ? PW'(diff + (PW+1)'(PROGRAM_WORDS)) : diff[PW-1:0];
					end else begin
						pc_new = (sum >= (PW+1)'(PROGRAM_WORDS)) ?
							PW'(sum - (PW+1)'(PROGRAM_WORDS)) : sum[PW-1:0];
					end
				end
			end
			OP_BR: begin
				taken  = 1'b1;
				pc_new = mod_prog(a_val | b_val);
			end
			default: begin
			end
		endcase
		pc_ext = {10'd0, pc_new};
	end

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			flags_q <= '0;
		end else if (s1_fire) begin
			pc_q <= pc_new;
			if (res.set_flags) begin
				flags_q <= res.flags;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			next_pc_q   <= pc_ext[9:0];
			flags_out_q <= res.set_flags ? res.flags : flags_q;
			reg_value_q <= res.wr_reg ? res.result : a_val;
			taken_q     <= taken;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pc      = next_pc_q;
	assign status_flags = flags_out_q;
	assign reg_value    = $signed(reg_value_q);
	assign branch_taken = taken_q;

	// checks
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1_q)
		else $error("input stalled with empty execute stage");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(pc_q) && $stable(flags_q)))
		else $error("state changed while output stalled");

	a_exec_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> out_valid)
		else $error("executed item did not reach output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1_q) |=> !out_valid)
		else $error("output item repeated");

endmodule

`default_nettype wire

// File: test/ebrx_exec_checker.sv
`default_nettype none

module ebrx_exec_checker
	import ebrx_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [3:0]          op_code,
	input  wire logic [IDX_W-1:0]    dest_reg,
	input  wire logic [IDX_W-1:0]    operand,
	input  wire logic                imm_negative,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [9:0]          next_pc,
	input  wire logic [FLAGS_W-1:0]  status_flags,
	input  wire logic [DATA_W-1:0]   reg_value,
	input  wire logic                branch_taken,
	output int                       mismatch_count,
	output int                       retire_pending
);

	// architectural outcome of one instruction
	typedef struct packed {
		logic [9:0]         pc;
		logic [FLAGS_W-1:0] flags;
		logic [DATA_W-1:0]  value;
		logic               taken;
	} retire_t;

	// shadow copy of the machine state
	logic [DATA_W-1:0]  shadow_regs [64];
	logic [DATA_W-1:0]  shadow_mem [64];
	logic [9:0]         shadow_pc;
	logic [FLAGS_W-1:0] shadow_flags;
	retire_t            retired_q [$];
	retire_t            got;

	// status flags from an 8-bit result
	function automatic logic [FLAGS_W-1:0] flags_of(logic [7:0] r, logic ov, logic cy);
		logic [FLAGS_W-1:0] f;
		f = '0;
		f[FLAG_Z] = (r == 8'd0);
		f[FLAG_N] = r[7];
		f[FLAG_V] = ov;
		f[FLAG_C] = cy;
		f[FLAG_S] = r[7] ^ ov;
		return f;
	endfunction

	// execute one instruction on the shadow state and queue its outcome
	task automatic execute_instruction(input logic [3:0] opc, input logic [5:0] rd,
			input logic [5:0] opd, input logic neg);
		logic [7:0]        a;
		logic [7:0]        b;
		logic [7:0]        imm;
		logic [7:0]        r;
		logic [8:0]        w9;
		logic [15:0]       prod;
		logic [23:0]       shl;
		logic signed [7:0] sa;
		logic              taken;
		retire_t           rec;
		a = shadow_regs[rd];
		b = shadow_regs[opd];
		imm = neg ? (8'd0 - {2'b00, opd}) : {2'b00, opd};
		taken = 1'b0;
		shadow_pc = shadow_pc + 10'd1;
		case (opc)
			OP_ADD: begin
				w9 = {1'b0, a} + {1'b0, b};
				r = w9[7:0];
				shadow_flags = flags_of(r, ~(a[7] ^ b[7]) & (a[7] ^ r[7]), w9[8]);
				shadow_regs[rd] = r;
			end
			OP_SUB: begin
				w9 = {1'b0, a} - {1'b0, b};
				r = w9[7:0];
				shadow_flags = flags_of(r, (a[7] ^ b[7]) & (a[7] ^ r[7]), w9[8]);
				shadow_regs[rd] = r;
			end
			OP_MUL: begin
				prod = {8'd0, a} * {8'd0, b};
				r = prod[7:0];
				shadow_flags = flags_of(r, 1'b0, prod[8]);
				shadow_regs[rd] = r;
			end
			OP_MOVI: begin
				shadow_regs[rd] = imm;
			end
			OP_BEQZ: begin
				// taken even with a zero offset
				if (a == 8'd0) begin
					taken = 1'b1;
					shadow_pc = neg ? shadow_pc - {4'b0, opd} : shadow_pc + {4'b0, opd};
				end
			end
			OP_ANDI: begin
				r = a & imm;
				shadow_flags = flags_of(r, 1'b0, 1'b0);
				shadow_regs[rd] = r;
			end
			OP_EOR: begin
				r = a ^ b;
				shadow_flags = flags_of(r, 1'b0, 1'b0);
				shadow_regs[rd] = r;
			end
			OP_BR: begin
				shadow_pc = {2'b00, a | b};
				taken = 1'b1;
			end
			OP_SAL: begin
				// wide shift covers large and negative amounts
				shl = {16'b0, a} << imm;
				r = shl[7:0];
				shadow_flags = flags_of(r, 1'b0, shl[8]);
				shadow_regs[rd] = r;
			end
			OP_SAR: begin
				sa = a;
				if (imm >= 8'd8)
					r = {8{a[7]}};
				else
					r = sa >>> imm[2:0];
				shadow_flags = flags_of(r, 1'b0, 1'b0);
				shadow_regs[rd] = r;
			end
			OP_LDR: begin
				shadow_regs[rd] = shadow_mem[opd];
			end
			OP_STR: begin
				shadow_mem[opd] = a;
			end
			default: begin
			end
		endcase
		rec.pc = shadow_pc;
		rec.flags = shadow_flags;
		rec.value = shadow_regs[rd];
		rec.taken = taken;
		retired_q.push_back(rec);
	endtask

	// compare retiring items, then predict newly issued ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) begin
				shadow_regs[i] = '0;
				shadow_mem[i] = '0;
			end
			shadow_pc = '0;
			shadow_flags = '0;
			retired_q.delete();
			mismatch_count = 0;
			retire_pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (retired_q.size() == 0) begin
					$error("result item with nothing outstanding: next_pc %0d", next_pc);
					mismatch_count++;
				end else begin
					got = retired_q.pop_front();
					if (next_pc !== got.pc) begin
						$error("next_pc mismatch: expected %0d, actual %0d", got.pc, next_pc);
						mismatch_count++;
					end
					if (status_flags !== got.flags) begin
						$error("status_flags mismatch: expected %b, actual %b",
							got.flags, status_flags);
						mismatch_count++;
					end
					if (reg_value !== got.value) begin
						$error("reg_value mismatch: expected %0d, actual %0d",
							$signed(got.value), $signed(reg_value));
						mismatch_count++;
					end
					if (branch_taken !== got.taken) begin
						$error("branch_taken mismatch: expected %b, actual %b",
							got.taken, branch_taken);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				execute_instruction(op_code, dest_reg, operand, imm_negative);
			retire_pending = retired_q.size();
		end
	end

endmodule

`default_nettype wire

// File: test/tb_eight_bit_risc_execute.sv
`default_nettype none

module tb_eight_bit_risc_execute;
	import ebrx_pkg::*;

	localparam logic [3:0] OP_UNUSED_LO = 4'd12;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_INSTRS = 1100;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 80;
	localparam int QUIET_FROM    = 600;
	localparam int QUIET_TO      = 800;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [3:0]              op_code = '0;
	logic [IDX_W-1:0]        dest_reg = '0;
	logic [IDX_W-1:0]        operand = '0;
	logic                    imm_negative = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [9:0]              next_pc;
	logic [FLAGS_W-1:0]      status_flags;
	logic signed [DATA_W-1:0] reg_value;
	logic                    branch_taken;

	int mismatch_count;
	int retire_pending;
	int sent_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	eight_bit_risc_execute dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op_code      (op_code),
		.dest_reg     (dest_reg),
		.operand      (operand),
		.imm_negative (imm_negative),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.next_pc      (next_pc),
		.status_flags (status_flags),
		.reg_value    (reg_value),
		.branch_taken (branch_taken)
	);

	ebrx_exec_checker exec_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op_code        (op_code),
		.dest_reg       (dest_reg),
		.operand        (operand),
		.imm_negative   (imm_negative),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_pc        (next_pc),
		.status_flags   (status_flags),
		.reg_value      (reg_value),
		.branch_taken   (branch_taken),
		.mismatch_count (mismatch_count),
		.retire_pending (retire_pending)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stretch of the run with no idling on either side
	function automatic bit quiet_stretch();
		return sent_count >= QUIET_FROM && sent_count < QUIET_TO;
	endfunction

	// result side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!hold_done && sent_count >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet_stretch()) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 38);
		end
	end

	// offer one item and hold it until taken
	task automatic send_instr(input logic [3:0] opc, input logic [5:0] rd,
			input logic [5:0] opd, input logic neg);
		while (!quiet_stretch() && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op_code <= opc;
		dest_reg <= rd;
		operand <= opd;
		imm_negative <= neg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	// random instruction, registers mostly from a small set so values interact
	task automatic random_instr();
		logic [3:0] opc;
		logic [5:0] rd;
		logic [5:0] opd;
		if ($urandom_range(9) == 0)
			opc = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
		else
			opc = 4'($urandom_range(int'(OP_STR)));
		rd = ($urandom_range(9) < 7) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
		opd = ($urandom_range(9) < 7) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
		// clearing a register now and then feeds taken beqz
		if (opc == OP_EOR && $urandom_range(1))
			opd = rd;
		send_instr(opc, rd, opd, 1'($urandom_range(1)));
	endtask

	// stimulus and verdict
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// arithmetic with signed overflow and borrow
		send_instr(OP_MOVI, 6'd1, 6'd63, 1'b0);
		send_instr(OP_ADD, 6'd1, 6'd1, 1'b0);
		send_instr(OP_MOVI, 6'd2, 6'd2, 1'b0);
		send_instr(OP_ADD, 6'd1, 6'd2, 1'b0);
		send_instr(OP_SUB, 6'd1, 6'd2, 1'b0);
		send_instr(OP_SUB, 6'd3, 6'd2, 1'b0);
		send_instr(OP_MUL, 6'd1, 6'd1, 1'b0);
		// minus zero immediate, then branches on zero and nonzero registers
		send_instr(OP_MOVI, 6'd3, 6'd0, 1'b1);
		send_instr(OP_BEQZ, 6'd3, 6'd0, 1'b0);
		send_instr(OP_BEQZ, 6'd3, 6'd63, 1'b1);
		send_instr(OP_BEQZ, 6'd1, 6'd63, 1'b0);
		// logic ops with a negative mask
		send_instr(OP_MOVI, 6'd4, 6'd63, 1'b1);
		send_instr(OP_ANDI, 6'd4, 6'd63, 1'b1);
		send_instr(OP_EOR, 6'd4, 6'd4, 1'b0);
		// shifts: normal, large and negative amounts
		send_instr(OP_MOVI, 6'd5, 6'd63, 1'b1);
		send_instr(OP_SAR, 6'd5, 6'd3, 1'b0);
		send_instr(OP_SAL, 6'd5, 6'd1, 1'b0);
		send_instr(OP_SAL, 6'd5, 6'd9, 1'b0);
		send_instr(OP_SAL, 6'd2, 6'd1, 1'b1);
		send_instr(OP_SAR, 6'd5, 6'd8, 1'b0);
		// data store at the top address, branch through registers
		send_instr(OP_MOVI, 6'd63, 6'd63, 1'b1);
		send_instr(OP_STR, 6'd63, 6'd63, 1'b0);
		send_instr(OP_LDR, 6'd0, 6'd63, 1'b0);
		send_instr(OP_BR, 6'd63, 6'd5, 1'b0);
		for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
			send_instr(4'(c), 6'(c), 6'(c), 1'b1);

		repeat (RANDOM_INSTRS)
			random_instr();
		in_valid <= 1'b0;

		do @(negedge clk); while (retire_pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d instructions executed, directed cases then random mixes of all opcodes,",
			sent_count);
		$display("with random stalls on both sides and a %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (mismatch_count == 0 && retire_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
